/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition and consequence in the same cycle.
`define DLL_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define DLL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* hdl/dll_pkg.sv */
// Package with sizes, codes, interface structs and helper functions of the list engine.
`default_nettype none
package dll_pkg;

    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY + 1);
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int IN_W        = 32;
    localparam int OP_W        = 3;
    localparam int ST_W        = 2;

    localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_INS_FIRST  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_LAST   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
    localparam logic [OP_W-1:0] OP_READ       = 3'd5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

    localparam logic [2:0] C_NONE  = 3'd0;
    localparam logic [2:0] C_LOAD  = 3'd1;
    localparam logic [2:0] C_START = 3'd2;
    localparam logic [2:0] C_STEP  = 3'd3;
    localparam logic [2:0] C_FOUND = 3'd4;
    localparam logic [2:0] C_INS1  = 3'd5;
    localparam logic [2:0] C_INS2  = 3'd6;
    localparam logic [2:0] C_DEL   = 3'd7;

    typedef struct packed {
        logic [2:0]      kind;
        logic            emit;
        logic            emit_rd;
        logic [ST_W-1:0] emit_status;
        logic            emit_last;
    } dll_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            head_nil;
        logic            full;
        logic            hit;
        logic            nxt_nil;
        logic            step_lim;
        logic            out_room;
    } dll_stat_t;

    function automatic logic [VALUE_WIDTH-1:0] norm_value(input logic [IN_W-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(signed'(raw));
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [IN_W-1:0] out_word(input logic [VALUE_WIDTH-1:0] v);
        logic [63:0] z;
        z = 64'(v);
        return z[IN_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/dll_ram.sv */
// Generic single write port RAM with one registered read port.
`default_nettype none
module dll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* hdl/dll_datapath.sv */
// Datapath: node and free stack memories, list pointers, cursor and output register.
`default_nettype none
module dll_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [dll_pkg::OP_W-1:0]  s_tuser,
    input  wire logic [2*dll_pkg::IN_W-1:0] s_tdata,
    input  wire dll_pkg::dll_cmd_t         cmd,
    output dll_pkg::dll_stat_t             stat,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [dll_pkg::IN_W-1:0]       m_tdata,
    output logic [dll_pkg::ST_W-1:0]       m_tuser,
    output logic                           m_tlast
);
    import dll_pkg::*;

    logic [OP_W-1:0]        op_reg;
    logic [VALUE_WIDTH-1:0] elem_reg;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [IDX_W-1:0]       fcnt_reg, fcnt_next;
    logic [IDX_W-1:0]       cur_reg;
    logic [IDX_W-1:0]       steps_reg;
    logic [IDX_W-1:0]       cprev_reg;
    logic [IDX_W-1:0]       cnext_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [CAPACITY-1:0]    fsv_reg;
    logic [SLOT_W-1:0]      fs_raddr_reg;
    logic                   ovalid_reg;
    logic [ST_W-1:0]        ostat_reg;
    logic [IN_W-1:0]        oval_reg;
    logic                   olast_reg;

    logic [VALUE_WIDTH-1:0] val_q;
    logic [IDX_W-1:0]       nxt_q, prv_q;
    logic [SLOT_W-1:0]      fs_q, fs_slot, fs_raddr;
    logic [IDX_W-1:0]       fcnt_m1;
    logic [SLOT_W-1:0]      rd_addr;
    logic [IDX_W-1:0]       rd_idx;
    logic                   val_we, nxt_we, prv_we, fs_we;
    logic [SLOT_W-1:0]      val_wa, nxt_wa, prv_wa, fs_wa;
    logic [IDX_W-1:0]       nxt_wd, prv_wd;
    logic [IDX_W-1:0]       slot_idx;
    logic [VALUE_WIDTH-1:0] target;
    logic                   out_room;

    assign fcnt_m1  = fcnt_reg - IDX_W'(1);
    assign fs_raddr = fcnt_m1[SLOT_W-1:0];
    // Entries never pushed read as the slot's own index, chosen by the fsv_reg valid bits.
    assign fs_slot  = fsv_reg[fs_raddr_reg] ? fs_q : fs_raddr_reg;
    assign slot_idx = IDX_W'(slot_reg);
    assign target   = (op_reg == OP_DELETE) ? elem_reg : key_reg;
    assign out_room = !ovalid_reg || m_tready;

    always_comb
    begin
        rd_idx = cur_reg;
        if (cmd.kind == C_START)
        begin
            rd_idx = head_reg;
        end
        else if (cmd.kind == C_STEP)
        begin
            rd_idx = nxt_q;
        end
        rd_addr = rd_idx[SLOT_W-1:0];
    end

    always_comb
    begin
        stat.op       = op_reg;
        stat.head_nil = head_reg >= NIL;
        stat.full     = fcnt_reg == '0;
        stat.hit      = val_q == target;
        stat.nxt_nil  = nxt_q >= NIL;
        stat.step_lim = steps_reg == IDX_W'(CAPACITY - 1);
        stat.out_room = out_room;
    end

    always_comb
    begin
        val_we    = 1'b0;
        nxt_we    = 1'b0;
        prv_we    = 1'b0;
        fs_we     = 1'b0;
        val_wa    = fs_slot;
        nxt_wa    = fs_slot;
        prv_wa    = fs_slot;
        fs_wa     = fcnt_reg[SLOT_W-1:0];
        nxt_wd    = NIL;
        prv_wd    = NIL;
        head_next = head_reg;
        tail_next = tail_reg;
        fcnt_next = fcnt_reg;
        case (cmd.kind)
            C_INS1:
            begin
                val_we = 1'b1;
                nxt_we = 1'b1;
                prv_we = 1'b1;
                case (op_reg)
                    OP_INS_FIRST:  nxt_wd = head_reg;
                    OP_INS_LAST:   prv_wd = tail_reg;
                    OP_INS_BEFORE:
                    begin
                        nxt_wd = cur_reg;
                        prv_wd = cprev_reg;
                    end
                    OP_INS_AFTER:
                    begin
                        nxt_wd = cnext_reg;
                        prv_wd = cur_reg;
                    end
                    default: ;
                endcase
            end
            C_INS2:
            begin
                fcnt_next = fcnt_m1;
                nxt_wd    = slot_idx;
                prv_wd    = slot_idx;
                case (op_reg)
                    OP_INS_FIRST:
                    begin
                        prv_we    = head_reg < NIL;
                        prv_wa    = head_reg[SLOT_W-1:0];
                        head_next = slot_idx;
                        if (head_reg >= NIL)
                        begin
                            tail_next = slot_idx;
                        end
                    end
                    OP_INS_LAST:
                    begin
                        nxt_we    = head_reg < NIL;
                        nxt_wa    = tail_reg[SLOT_W-1:0];
                        tail_next = slot_idx;
                        if (head_reg >= NIL)
                        begin
                            head_next = slot_idx;
                        end
                    end
                    OP_INS_BEFORE:
                    begin
                        nxt_we = cprev_reg < NIL;
                        nxt_wa = cprev_reg[SLOT_W-1:0];
                        if (cprev_reg >= NIL)
                        begin
                            head_next = slot_idx;
                        end
                        prv_we = 1'b1;
                        prv_wa = cur_reg[SLOT_W-1:0];
                    end
                    OP_INS_AFTER:
                    begin
                        prv_we = cnext_reg < NIL;
                        prv_wa = cnext_reg[SLOT_W-1:0];
                        if (cnext_reg >= NIL)
                        begin
                            tail_next = slot_idx;
                        end
                        nxt_we = 1'b1;
                        nxt_wa = cur_reg[SLOT_W-1:0];
                    end
                    default: ;
                endcase
            end
            C_DEL:
            begin
                nxt_wd = cnext_reg;
                prv_wd = cprev_reg;
                nxt_we = cprev_reg < NIL;
                nxt_wa = cprev_reg[SLOT_W-1:0];
                prv_we = cnext_reg < NIL;
                prv_wa = cnext_reg[SLOT_W-1:0];
                if (cprev_reg >= NIL)
                begin
                    head_next = cnext_reg;
                end
                if (cnext_reg >= NIL)
                begin
                    tail_next = cprev_reg;
                end
                if (fcnt_reg < IDX_W'(CAPACITY))
                begin
                    fs_we     = 1'b1;
                    fcnt_next = fcnt_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    dll_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_wa),
        .wdata (elem_reg),
        .raddr (rd_addr),
        .rdata (val_q)
    );

    dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_nxt_ram (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_wa),
        .wdata (nxt_wd),
        .raddr (rd_addr),
        .rdata (nxt_q)
    );

    dll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_prv_ram (
        .clk   (clk),
        .we    (prv_we),
        .waddr (prv_wa),
        .wdata (prv_wd),
        .raddr (rd_addr),
        .rdata (prv_q)
    );

    dll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_fs_ram (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_wa),
        .wdata (cur_reg[SLOT_W-1:0]),
        .raddr (fs_raddr),
        .rdata (fs_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= NIL;
            tail_reg   <= NIL;
            fcnt_reg   <= IDX_W'(CAPACITY);
            fsv_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fcnt_reg <= fcnt_next;
            if (fs_we)
            begin
                fsv_reg[fs_wa] <= 1'b1;
            end
            if (cmd.emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fs_raddr_reg <= fs_raddr;
        case (cmd.kind)
            C_LOAD:
            begin
                op_reg   <= s_tuser;
                elem_reg <= norm_value(s_tdata[IN_W-1:0]);
                key_reg  <= norm_value(s_tdata[2*IN_W-1:IN_W]);
            end
            C_START:
            begin
                cur_reg   <= head_reg;
                steps_reg <= '0;
            end
            C_STEP:
            begin
                cur_reg   <= nxt_q;
                steps_reg <= steps_reg + IDX_W'(1);
            end
            C_FOUND:
            begin
                cprev_reg <= prv_q;
                cnext_reg <= nxt_q;
            end
            C_INS1: slot_reg <= fs_slot;
            default: ;
        endcase
        if (cmd.emit)
        begin
            ostat_reg <= cmd.emit_status;
            oval_reg  <= cmd.emit_rd ? out_word(val_q) : '0;
            olast_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oval_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

endmodule
`default_nettype wire

/* hdl/dll_ctrl.sv */
// Controller state machine that sequences each operation over the datapath.
`default_nettype none
module dll_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire dll_pkg::dll_stat_t stat,
    output dll_pkg::dll_cmd_t       cmd
);
    import dll_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_INS1 = 3'd3;
    localparam logic [2:0] S_INS2 = 3'd4;
    localparam logic [2:0] S_DEL  = 3'd5;
    localparam logic [2:0] S_READ = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]      state_reg, state_next;
    logic [ST_W-1:0] stat_reg, stat_next;
    logic            rd_last;

    assign rd_last = stat.nxt_nil || stat.step_lim;

    always_comb
    begin
        state_next      = state_reg;
        stat_next       = stat_reg;
        s_tready        = 1'b0;
        cmd.kind        = C_NONE;
        cmd.emit        = 1'b0;
        cmd.emit_rd     = 1'b0;
        cmd.emit_status = stat_reg;
        cmd.emit_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.kind   = C_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.op)
                    OP_INS_FIRST, OP_INS_LAST:
                    begin
                        if (stat.full)
                        begin
                            stat_next  = ST_FULL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_INS1;
                        end
                    end
                    OP_INS_BEFORE, OP_INS_AFTER, OP_DELETE:
                    begin
                        if (stat.head_nil)
                        begin
                            stat_next  = ST_NOTFOUND;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.kind   = C_START;
                            state_next = S_SRCH;
                        end
                    end
                    OP_READ:
                    begin
                        if (stat.head_nil)
                        begin
                            stat_next  = ST_EMPTY;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.kind   = C_START;
                            state_next = S_READ;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SRCH:
            begin
                if (stat.hit)
                begin
                    cmd.kind = C_FOUND;
                    if (stat.op == OP_DELETE)
                    begin
                        state_next = S_DEL;
                    end
                    else if (stat.full)
                    begin
                        stat_next  = ST_FULL;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_INS1;
                    end
                end
                else if (rd_last)
                begin
                    stat_next  = ST_NOTFOUND;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.kind = C_STEP;
                end
            end
            S_INS1:
            begin
                cmd.kind   = C_INS1;
                state_next = S_INS2;
            end
            S_INS2:
            begin
                cmd.kind   = C_INS2;
                stat_next  = ST_OK;
                state_next = S_EMIT;
            end
            S_DEL:
            begin
                cmd.kind   = C_DEL;
                stat_next  = ST_OK;
                state_next = S_EMIT;
            end
            S_READ:
            begin
                if (stat.out_room)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_rd     = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_last   = rd_last;
                    if (rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.kind = C_STEP;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.out_room)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

endmodule
`default_nettype wire

/* hdl/doubly_linked_list_engine_top.sv */
// Top level of the bounded doubly linked list engine.
//
//  Channel   Dir   tdata                         tuser          tlast
//  s_*       in    element [31:0], key [63:32]   opcode [2:0]   -
//  m_*       out   value [31:0]                  status [1:0]   last result of the item
//
// One item is taken at a time. Head and tail inserts need no search; a search walks
// one node per cycle through the node memories for insert before/after and delete,
// and ends when the key is found or the end of the list is reached.
// A read out gives one element per cycle while m_tready is high.
// The result register is freed when the output is taken; a stalled output holds the walk.
// Reset empties the list at once; no clearing pass is needed.
`default_nettype none
module doubly_linked_list_engine_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [2*dll_pkg::IN_W-1:0]  s_tdata,  // element, key
    input  wire logic [dll_pkg::OP_W-1:0]    s_tuser,  // opcode
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dll_pkg::IN_W-1:0]         m_tdata,  // value
    output logic [dll_pkg::ST_W-1:0]         m_tuser,  // status
    output logic                             m_tlast
);
    import dll_pkg::*;

    dll_cmd_t  cmd;
    dll_stat_t stat;

    dll_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dll_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

/* hdl/dll_checker.sv */
// Port level checker for the list engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module dll_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic [2*dll_pkg::IN_W-1:0]  s_tdata,
    input wire logic [dll_pkg::OP_W-1:0]    s_tuser,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [dll_pkg::IN_W-1:0]    m_tdata,
    input wire logic [dll_pkg::ST_W-1:0]    m_tuser,
    input wire logic                        m_tlast
);
    import dll_pkg::*;

    `DLL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled result changed")
    `DLL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "second item taken while one is in work")
    `DLL_ASSERT_SAME(a_status_single, m_tvalid && m_tuser != ST_OK,
        m_tlast && m_tdata == '0, "status result is not a single zero valued item")

endmodule

bind doubly_linked_list_engine_top dll_checker u_dll_checker (.*);
`default_nettype wire
